>>> rtl/core/icrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icrm_pkg
// Shared types, sizes and helpers for the IPv4 CIDR range matcher.
// ----------------------------------------------------------------------------
package icrm_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ADDR_W      = 32;
    localparam int PLEN_W      = 6;
    localparam int ECNT_W      = 9;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QFILL_W     = $clog2(QDEPTH + 1);

    localparam logic [ADDR_W-1:0] FULL_MASK = 32'hFFFF_FFFF;
    localparam logic [PLEN_W-1:0] PLEN_MAX  = 6'd32;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
        logic [PLEN_W-1:0] prefix_len;
    } req_word_t;

    typedef struct packed {
        logic              matched;
        logic              status;
        logic [ECNT_W-1:0] entry_count;
    } rsp_word_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] mask;
    } entry_t;

    function automatic logic [ADDR_W-1:0] mask_from_prefix(input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0] m;
        if (plen >= PLEN_MAX)
        begin
            m = FULL_MASK;
        end
        else
        begin
            m = ~(FULL_MASK >> plen);
        end
        return m;
    endfunction

endpackage

>>> rtl/core/icrm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module icrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/icrm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icrm_front
// Accepts request words, builds the range mask and classifies the operation.
// ----------------------------------------------------------------------------
module icrm_front (
    input  logic                req_valid,
    output logic                req_ready,
    input  icrm_pkg::req_word_t req,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output icrm_pkg::cmd_t      cmd
);

    logic [icrm_pkg::ADDR_W-1:0] mask;

    assign mask      = icrm_pkg::mask_from_prefix(req.prefix_len);
    assign cmd_valid = req_valid;
    assign req_ready = cmd_ready;

    always_comb
    begin
        cmd.addr = req.address;
        cmd.mask = mask;
        unique case (icrm_pkg::action_t'(req.action))
            icrm_pkg::ACT_CLEAR:
            begin
                cmd.op = icrm_pkg::OP_CLEAR;
            end
            icrm_pkg::ACT_ADD:
            begin
                cmd.op   = icrm_pkg::OP_ADD;
                cmd.addr = req.address & mask;
            end
            icrm_pkg::ACT_LOOKUP:
            begin
                // address zero never matches
                cmd.op = (req.address == '0) ? icrm_pkg::OP_NOP : icrm_pkg::OP_LOOKUP;
            end
            default:
            begin
                cmd.op = icrm_pkg::OP_NOP;
            end
        endcase
    end

endmodule

>>> rtl/core/icrm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icrm_queue
// Short command FIFO between the front end and the table engine.
// ----------------------------------------------------------------------------
module icrm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  icrm_pkg::cmd_t push_word,
    output logic           pop_valid,
    input  logic           pop_ready,
    output icrm_pkg::cmd_t pop_word
);

    icrm_pkg::cmd_t                mem_reg [icrm_pkg::QDEPTH];
    logic [icrm_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [icrm_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [icrm_pkg::QFILL_W-1:0]  fill_reg, fill_next;
    logic                          do_push, do_pop;

    assign push_ready = (fill_reg != icrm_pkg::QFILL_W'(icrm_pkg::QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == icrm_pkg::QPTR_W'(icrm_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + icrm_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == icrm_pkg::QPTR_W'(icrm_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + icrm_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + icrm_pkg::QFILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - icrm_pkg::QFILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

>>> rtl/core/icrm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icrm_back
// Table engine: clears, appends ranges and scans the table for lookups.
// ----------------------------------------------------------------------------
module icrm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  icrm_pkg::cmd_t      cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output icrm_pkg::rsp_word_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [icrm_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [icrm_pkg::IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [icrm_pkg::ADDR_W-1:0]   lk_addr_reg, lk_addr_next;
    logic                          ovalid_reg, ovalid_next;
    icrm_pkg::rsp_word_t           rsp_reg, rsp_next;

    logic                          out_free, full, hit, last;
    logic                          ram_we, ram_re;
    logic [icrm_pkg::IDX_W-1:0]    ram_raddr;
    icrm_pkg::entry_t              ram_wdata, ram_rdata;

    icrm_ram #(
        .WIDTH ($bits(icrm_pkg::entry_t)),
        .DEPTH (icrm_pkg::MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[icrm_pkg::IDX_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !ovalid_reg || rsp_ready;
    assign full      = (count_reg >= icrm_pkg::CNT_W'(icrm_pkg::MAX_ENTRIES));
    assign hit       = ((lk_addr_reg & ram_rdata.mask) == ram_rdata.base);
    assign last      = ((icrm_pkg::CNT_W'(rd_idx_reg) + icrm_pkg::CNT_W'(1)) == count_reg);
    assign ram_wdata = '{base: cmd.addr, mask: cmd.mask};
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign rsp_valid = ovalid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        lk_addr_next = lk_addr_reg;
        ovalid_next  = ovalid_reg && !rsp_ready;
        rsp_next     = rsp_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = rd_idx_reg + icrm_pkg::IDX_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    rsp_next = '{matched: 1'b0, status: 1'b0,
                                 entry_count: icrm_pkg::ECNT_W'(count_reg)};
                    unique case (cmd.op)
                        icrm_pkg::OP_CLEAR:
                        begin
                            count_next           = '0;
                            rsp_next.entry_count = '0;
                            ovalid_next          = 1'b1;
                        end
                        icrm_pkg::OP_ADD:
                        begin
                            if (full)
                            begin
                                rsp_next.status = 1'b1;
                            end
                            else
                            begin
                                ram_we               = 1'b1;
                                count_next           = count_reg + icrm_pkg::CNT_W'(1);
                                rsp_next.entry_count = icrm_pkg::ECNT_W'(count_next);
                            end
                            ovalid_next = 1'b1;
                        end
                        icrm_pkg::OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = '0;
                                rd_idx_next  = '0;
                                lk_addr_next = cmd.addr;
                                state_next   = S_SCAN;
                            end
                        end
                        default:
                        begin
                            ovalid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit || last)
                begin
                    rsp_next    = '{matched: hit, status: 1'b0,
                                    entry_count: icrm_pkg::ECNT_W'(count_reg)};
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + icrm_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        lk_addr_reg <= lk_addr_next;
        rsp_reg     <= rsp_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= icrm_pkg::CNT_W'(icrm_pkg::MAX_ENTRIES))
        else $error("entry count above table size");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !ram_we)
        else $error("table write during scan");

    a_no_rsp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !ovalid_reg)
        else $error("response pending while scanning");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd.op == icrm_pkg::OP_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty table");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (icrm_pkg::CNT_W'(rd_idx_reg) < count_reg))
        else $error("scan index past stored entries");
`endif

endmodule

>>> rtl/core/ipv4_cidr_range_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_cidr_range_match
// IPv4 CIDR range table with add, clear and address lookup.
// ----------------------------------------------------------------------------
// Each request word yields exactly one response word, in order. Clear, add
// and ignored words are handled by the table engine straight from idle, as
// are a lookup of address zero and a lookup against an empty table. Any other
// lookup reads the entry RAM one entry a cycle and holds the engine until it
// has read the first hit, or all stored entries when nothing hits (at most
// 256). A two-word queue lets requests be accepted while a lookup scan is
// running or a response waits to be taken. No clearing pass after reset: the
// table is valid as soon as rst_n is released.
// ----------------------------------------------------------------------------
module ipv4_cidr_range_match (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  icrm_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output icrm_pkg::rsp_word_t rsp
);

    logic           f_valid, f_ready;
    icrm_pkg::cmd_t f_cmd;
    logic           q_valid, q_ready;
    icrm_pkg::cmd_t q_cmd;

    icrm_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    icrm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_word  (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_cmd)
    );

    icrm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> dv/ipv4_cidr_range_match_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_cidr_range_match_test
// Self-checking testbench for the IPv4 CIDR range matcher.
// ----------------------------------------------------------------------------
// A short directed table walks the prefix extremes, the zero-address miss,
// the catch-all zero prefix, the ignored action and clears. Random episodes
// follow: clear, a run of adds (a few run the table past full), then
// lookups, about half aimed inside stored ranges. Each response word is
// compared field by field against its directed row or a local range-table
// model, with random idle gaps on both sides and long response hold-offs.
// ----------------------------------------------------------------------------
module ipv4_cidr_range_match_test;

    localparam int RAND_ITEMS = 1750;
    localparam int DIR_ROWS   = 23;
    localparam int HOLD_LONG  = 400;

    typedef struct packed {
        icrm_pkg::action_t           act;
        logic [icrm_pkg::ADDR_W-1:0] addr;
        logic [icrm_pkg::PLEN_W-1:0] plen;
        logic                        known;
        logic                        m;
        logic                        s;
        logic [icrm_pkg::ECNT_W-1:0] cnt;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    icrm_pkg::req_word_t req;
    logic                rsp_valid;
    logic                rsp_ready;
    icrm_pkg::rsp_word_t rsp;

    logic [icrm_pkg::ADDR_W-1:0] tbl_base [icrm_pkg::MAX_ENTRIES];
    logic [icrm_pkg::ADDR_W-1:0] tbl_mask [icrm_pkg::MAX_ENTRIES];
    int                          tbl_count;

    icrm_pkg::rsp_word_t pending_rsp [$];
    int                  mismatch_count;
    int                  items_counted;
    int                  send_mode;
    int                  recv_mode;

    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{icrm_pkg::ACT_LOOKUP, 32'h0A00_0001, 6'd0,  1'b1, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_ADD,    32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 1'b0, 9'd1},
        '{icrm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b1, 1'b0, 9'd1},
        '{icrm_pkg::ACT_LOOKUP, 32'hFFFF_FFFE, 6'd5,  1'b0, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_ADD,    32'hC0A8_0155, 6'd63, 1'b1, 1'b0, 1'b0, 9'd2},
        '{icrm_pkg::ACT_LOOKUP, 32'hC0A8_0155, 6'd63, 1'b0, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_ADD,    32'hAC1F_FFFF, 6'd33, 1'b1, 1'b0, 1'b0, 9'd3},
        '{icrm_pkg::ACT_ADD,    32'h0A0B_0C0D, 6'd8,  1'b1, 1'b0, 1'b0, 9'd4},
        '{icrm_pkg::ACT_LOOKUP, 32'h0AFF_FFFF, 6'd0,  1'b0, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_LOOKUP, 32'h0B00_0000, 6'd0,  1'b0, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_ADD,    32'h8000_0000, 6'd1,  1'b1, 1'b0, 1'b0, 9'd5},
        '{icrm_pkg::ACT_LOOKUP, 32'h8000_0001, 6'd0,  1'b0, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_ADD,    32'h1234_5678, 6'd31, 1'b1, 1'b0, 1'b0, 9'd6},
        '{icrm_pkg::ACT_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0, 9'd6},
        '{icrm_pkg::ACT_LOOKUP, 32'h1234_5679, 6'd0,  1'b0, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_CLEAR,  32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_ADD,    32'hDEAD_BEEF, 6'd0,  1'b1, 1'b0, 1'b0, 9'd1},
        '{icrm_pkg::ACT_LOOKUP, 32'h0000_0001, 6'd0,  1'b0, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0, 9'd1},
        '{icrm_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 6'd0,  1'b0, 1'b0, 1'b0, 9'd0},
        '{icrm_pkg::ACT_CLEAR,  32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0, 9'd0}
    };

    ipv4_cidr_range_match dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int draw_wait(input int mode);
        int w;
        case (mode)
            0: w = 0;
            1: w = $urandom_range(0, 17);
            default: w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
        endcase
        return w;
    endfunction

    function automatic icrm_pkg::rsp_word_t cidr_table_step(input icrm_pkg::req_word_t w);
        icrm_pkg::rsp_word_t         r;
        int                          plen;
        logic [icrm_pkg::ADDR_W-1:0] m;
        r = '0;
        case (w.action)
            icrm_pkg::ACT_CLEAR:
            begin
                tbl_count = 0;
            end
            icrm_pkg::ACT_ADD:
            begin
                if (tbl_count >= icrm_pkg::MAX_ENTRIES)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    plen = (w.prefix_len > 6'd32) ? 32 : int'(w.prefix_len);
                    m = (plen == 0) ? '0 : (32'hFFFF_FFFF << (32 - plen));
                    tbl_base[tbl_count] = w.address & m;
                    tbl_mask[tbl_count] = m;
                    tbl_count++;
                end
            end
            icrm_pkg::ACT_LOOKUP:
            begin
                if (w.address != '0)
                begin
                    for (int i = 0; i < tbl_count; i++)
                    begin
                        if ((w.address & tbl_mask[i]) == tbl_base[i])
                        begin
                            r.matched = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = tbl_count[icrm_pkg::ECNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Drive one word, wait for the handshake, then queue its expected response.
    task automatic offer_word(input icrm_pkg::req_word_t w, input logic known,
                              input icrm_pkg::rsp_word_t want);
        int                  gap;
        icrm_pkg::rsp_word_t r;
        gap = draw_wait(send_mode);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        r = cidr_table_step(w);
        pending_rsp.push_back(known ? want : r);
        items_counted++;
        if (items_counted % 50 == 0)
        begin
            send_mode = $urandom_range(0, 2);
        end
    endtask

    task automatic offer_rand(input icrm_pkg::action_t a,
                              input logic [icrm_pkg::ADDR_W-1:0] addr,
                              input logic [icrm_pkg::PLEN_W-1:0] plen);
        icrm_pkg::req_word_t w;
        w.action     = a;
        w.address    = addr;
        w.prefix_len = plen;
        offer_word(w, 1'b0, '0);
    endtask

    // Lookup aimed inside a stored range, at random or at zero, or an ignored word or a clear.
    task automatic offer_probe();
        int                          pick;
        int                          idx;
        logic [icrm_pkg::ADDR_W-1:0] a;
        logic [icrm_pkg::PLEN_W-1:0] p;
        pick = $urandom_range(0, 49);
        a    = $urandom;
        p    = icrm_pkg::PLEN_W'($urandom_range(0, 63));
        if (pick < 25 && tbl_count > 0)
        begin
            idx = $urandom_range(0, tbl_count - 1);
            a   = tbl_base[idx] | ($urandom & ~tbl_mask[idx]);
            offer_rand(icrm_pkg::ACT_LOOKUP, a, p);
        end
        else if (pick < 40)
        begin
            offer_rand(icrm_pkg::ACT_LOOKUP, a, p);
        end
        else if (pick < 44)
        begin
            offer_rand(icrm_pkg::ACT_LOOKUP, '0, p);
        end
        else if (pick < 49)
        begin
            offer_rand(icrm_pkg::ACT_UNUSED, a, p);
        end
        else
        begin
            offer_rand(icrm_pkg::ACT_CLEAR, a, p);
        end
    endtask

    // Response side: random ready gaps plus two long hold-offs.
    initial
    begin
        int                  gap;
        int                  got;
        icrm_pkg::rsp_word_t want;
        rsp_ready <= 1'b0;
        got       = 0;
        recv_mode = 1;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = draw_wait(recv_mode);
            if (got == 40 || got == 900)
            begin
                gap = HOLD_LONG;
            end
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            got++;
            if (got % 64 == 0)
            begin
                recv_mode = $urandom_range(0, 2);
            end
            if (pending_rsp.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %h", rsp));
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.matched !== want.matched)
                begin
                    report_mismatch($sformatf("matched %b, want %b",
                                              rsp.matched, want.matched));
                end
                if (rsp.status !== want.status)
                begin
                    report_mismatch($sformatf("status %b, want %b",
                                              rsp.status, want.status));
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              rsp.entry_count, want.entry_count));
                end
            end
        end
    end

    initial
    begin
        icrm_pkg::req_word_t         w;
        icrm_pkg::rsp_word_t         want;
        int                          episode;
        int                          n_add;
        int                          n_look;
        int                          r;
        logic [icrm_pkg::PLEN_W-1:0] plen;
        rst_n          <= 1'b0;
        req_valid      <= 1'b0;
        req            <= '0;
        mismatch_count = 0;
        items_counted  = 0;
        tbl_count      = 0;
        send_mode      = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            w.action           = dir_rows[i].act;
            w.address          = dir_rows[i].addr;
            w.prefix_len       = dir_rows[i].plen;
            want.matched       = dir_rows[i].m;
            want.status        = dir_rows[i].s;
            want.entry_count   = dir_rows[i].cnt;
            offer_word(w, dir_rows[i].known, want);
        end

        // A few episodes run the table past full to hit the drop flag.
        episode = 0;
        while (items_counted < RAND_ITEMS)
        begin
            offer_rand(icrm_pkg::ACT_CLEAR, $urandom,
                       icrm_pkg::PLEN_W'($urandom_range(0, 63)));
            n_add  = (episode % 20 == 2) ? icrm_pkg::MAX_ENTRIES + $urandom_range(1, 4)
                                         : $urandom_range(0, 12);
            n_look = $urandom_range(8, 30);
            for (int k = 0; k < n_add && items_counted < RAND_ITEMS; k++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                begin
                    plen = '0;
                end
                else if (r < 3)
                begin
                    plen = icrm_pkg::PLEN_W'($urandom_range(33, 63));
                end
                else
                begin
                    plen = icrm_pkg::PLEN_W'($urandom_range(1, 32));
                end
                offer_rand(icrm_pkg::ACT_ADD, $urandom, plen);
                if ($urandom_range(0, 7) == 0)
                begin
                    offer_probe();
                end
            end
            for (int k = 0; k < n_look && items_counted < RAND_ITEMS; k++)
            begin
                offer_probe();
            end
            episode++;
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
